/* rtl/imuunp_pkg.sv */
`default_nettype none

package imuunp_pkg;

    localparam int COUNT_W = 10;
    localparam int GAIN_W = 32;
    localparam int TIME_W = 64;
    localparam int AXIS_W = 16;
    localparam int TAG_W = 5;
    localparam int NUM_AXES = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam int FIFO_LIMIT_DEFAULT = 256;

    localparam logic [GAIN_W-1:0] GYRO_GAIN_RESET = 32'd19260243;
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RESET = 32'd16767040;

    localparam logic [TAG_W-1:0] TAG_GYRO = 5'd1;
    localparam logic [TAG_W-1:0] TAG_ACCEL = 5'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_GAIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_GAIN = 1'd1;

    typedef enum logic [1:0] {
        CMD_PLAIN,
        CMD_GYRO,
        CMD_ACCEL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic next_is_data;
        logic fault;
        logic accel_fresh;
        logic [TIME_W-1:0] delta_us;
        logic [NUM_AXES-1:0][AXIS_W-1:0] raw;
    } cmd_t;

    typedef struct packed {
        logic push;
    } queue_status_t;

endpackage

`default_nettype wire

/* rtl/imuunp_if.sv */
`default_nettype none

interface imuunp_in_if;
    logic valid;
    logic ready;
    logic read_ok;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic [7:0] byte_six;
    logic [63:0] timestamp_us;

    modport source (
        output valid, read_ok, byte_zero, byte_one, byte_two, byte_three,
        output byte_four, byte_five, byte_six, timestamp_us,
        input ready
    );
    modport sink (
        input valid, read_ok, byte_zero, byte_one, byte_two, byte_three,
        input byte_four, byte_five, byte_six, timestamp_us,
        output ready
    );
endinterface

interface imuunp_out_if;
    logic valid;
    logic ready;
    logic next_is_data;
    logic sample_valid;
    logic accel_fresh;
    logic fault;
    logic [63:0] delta_ns;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (
        output valid, next_is_data, sample_valid, accel_fresh, fault, delta_ns,
        output rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
        input ready
    );
    modport sink (
        input valid, next_is_data, sample_valid, accel_fresh, fault, delta_ns,
        input rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/imuunp_front.sv */
`default_nettype none

module imuunp_front #(
    parameter int FIFO_LIMIT = imuunp_pkg::FIFO_LIMIT_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    imuunp_in_if.sink                  rd,
    input  wire logic                  queue_full,
    output imuunp_pkg::queue_status_t  status,
    output imuunp_pkg::cmd_t           cmd
);
    import imuunp_pkg::*;

    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(FIFO_LIMIT);

    logic data_mode_reg, data_mode_next;
    logic [COUNT_W-1:0] words_left_reg, words_left_next;
    logic accel_seen_reg, accel_seen_next;
    logic [TIME_W-1:0] last_gyro_time_reg, last_gyro_time_next;
    logic halted_reg, halted_next;

    logic push;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] words_dec;
    logic [TAG_W-1:0] tag;

    assign rd.ready = !queue_full;
    assign push = rd.valid && !queue_full;
    assign status.push = push;

    assign count = {rd.byte_one[1:0], rd.byte_zero};
    assign words_dec = words_left_reg - 1'b1;
    assign tag = rd.byte_zero[7:3];

    always_comb
    begin
        data_mode_next = data_mode_reg;
        words_left_next = words_left_reg;
        accel_seen_next = accel_seen_reg;
        last_gyro_time_next = last_gyro_time_reg;
        halted_next = halted_reg;

        cmd.kind = CMD_PLAIN;
        cmd.next_is_data = 1'b0;
        cmd.fault = 1'b0;
        cmd.accel_fresh = 1'b0;
        cmd.delta_us = '0;
        cmd.raw[0] = {rd.byte_two, rd.byte_one};
        cmd.raw[1] = {rd.byte_four, rd.byte_three};
        cmd.raw[2] = {rd.byte_six, rd.byte_five};

        if (halted_reg)
        begin
            cmd.fault = 1'b1;
        end
        else if (!rd.read_ok)
        begin
            cmd.next_is_data = data_mode_reg;
        end
        else if (!data_mode_reg)
        begin
            words_left_next = count;
            data_mode_next = (count != '0);
            if (count > LIMIT)
            begin
                halted_next = 1'b1;
                cmd.fault = 1'b1;
            end
            else
            begin
                cmd.next_is_data = (count != '0);
            end
        end
        else
        begin
            if (tag == TAG_GYRO)
            begin
                cmd.kind = CMD_GYRO;
                cmd.accel_fresh = accel_seen_reg;
                cmd.delta_us = rd.timestamp_us - last_gyro_time_reg;
                accel_seen_next = 1'b0;
                last_gyro_time_next = rd.timestamp_us;
            end
            else if (tag == TAG_ACCEL)
            begin
                cmd.kind = CMD_ACCEL;
                accel_seen_next = 1'b1;
            end
            words_left_next = words_dec;
            data_mode_next = (words_dec != '0);
            cmd.next_is_data = (words_dec != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg <= 1'b0;
            words_left_reg <= '0;
            accel_seen_reg <= 1'b0;
            last_gyro_time_reg <= '0;
            halted_reg <= 1'b0;
        end
        else if (push)
        begin
            data_mode_reg <= data_mode_next;
            words_left_reg <= words_left_next;
            accel_seen_reg <= accel_seen_next;
            last_gyro_time_reg <= last_gyro_time_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/imuunp_queue.sv */
`default_nettype none

module imuunp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  imuunp_pkg::queue_status_t  status,
    input  imuunp_pkg::cmd_t           push_cmd,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output imuunp_pkg::cmd_t           head
);
    import imuunp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_pop;

    assign full = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head = entries_reg[rd_ptr_reg];
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (status.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (status.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!status.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/imuunp_back.sv */
`default_nettype none

module imuunp_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [imuunp_pkg::GAIN_W-1:0] gyro_gain,
    input  wire logic [imuunp_pkg::GAIN_W-1:0] accel_gain,
    input  wire logic                     queue_not_empty,
    input  imuunp_pkg::cmd_t              head,
    output logic                          pop,
    imuunp_out_if.source                  res
);
    import imuunp_pkg::*;

    localparam int MAG_W = AXIS_W + 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int FRAC_W = 24;

    typedef struct packed {
        cmd_kind_t kind;
        logic next_is_data;
        logic fault;
        logic accel_fresh;
        logic [TIME_W-1:0] delta_ns;
        logic [NUM_AXES-1:0] neg;
        logic [NUM_AXES-1:0][AXIS_W-1:0] scaled;
    } stage_t;

    typedef struct packed {
        logic next_is_data;
        logic sample_valid;
        logic accel_fresh;
        logic fault;
        logic [TIME_W-1:0] delta_ns;
        logic [NUM_AXES-1:0][AXIS_W-1:0] rate;
        logic [NUM_AXES-1:0][AXIS_W-1:0] accel;
    } result_t;

    logic s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic out_valid_reg;
    result_t out_reg, out_next;
    logic [NUM_AXES-1:0][AXIS_W-1:0] held_accel_reg;
    logic [NUM_AXES-1:0][AXIS_W-1:0] axis_val;

    logic advance_out;
    logic move_s1;
    logic [GAIN_W-1:0] gain;
    logic [MAG_W-1:0] mag [NUM_AXES];
    logic [PROD_W-1:0] prod [NUM_AXES];

    assign advance_out = !out_valid_reg || res.ready;
    assign move_s1 = s1_valid_reg && advance_out;
    assign pop = queue_not_empty && (!s1_valid_reg || advance_out);

    assign gain = (head.kind == CMD_ACCEL) ? accel_gain : gyro_gain;

    always_comb
    begin
        s1_next.kind = head.kind;
        s1_next.next_is_data = head.next_is_data;
        s1_next.fault = head.fault;
        s1_next.accel_fresh = head.accel_fresh;
        s1_next.delta_ns = (head.delta_us << 10) - (head.delta_us << 4)
                         - (head.delta_us << 3);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s1_next.neg[i] = head.raw[i][AXIS_W-1];
            mag[i] = head.raw[i][AXIS_W-1]
                   ? (MAG_W'(1) << AXIS_W) - {1'b0, head.raw[i]}
                   : {1'b0, head.raw[i]};
            prod[i] = PROD_W'(mag[i]) * PROD_W'(gain);
            s1_next.scaled[i] = prod[i][FRAC_W +: AXIS_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_val[i] = s1_reg.neg[i] ? AXIS_W'(0) - s1_reg.scaled[i]
                                        : s1_reg.scaled[i];
        end
        out_next.next_is_data = s1_reg.next_is_data;
        out_next.fault = s1_reg.fault;
        out_next.sample_valid = (s1_reg.kind == CMD_GYRO);
        out_next.accel_fresh = s1_reg.accel_fresh;
        out_next.delta_ns = '0;
        out_next.rate = '0;
        out_next.accel = '0;
        if (s1_reg.kind == CMD_GYRO)
        begin
            out_next.delta_ns = s1_reg.delta_ns;
            out_next.rate = axis_val;
            out_next.accel = held_accel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            held_accel_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move_s1)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (move_s1)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (move_s1 && s1_reg.kind == CMD_ACCEL)
            begin
                held_accel_reg <= axis_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= s1_next;
        end
        if (move_s1)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.next_is_data = out_reg.next_is_data;
    assign res.sample_valid = out_reg.sample_valid;
    assign res.accel_fresh = out_reg.accel_fresh;
    assign res.fault = out_reg.fault;
    assign res.delta_ns = out_reg.delta_ns;
    assign res.rate_x = out_reg.rate[0];
    assign res.rate_y = out_reg.rate[1];
    assign res.rate_z = out_reg.rate[2];
    assign res.accel_x = out_reg.accel[0];
    assign res.accel_y = out_reg.accel[1];
    assign res.accel_z = out_reg.accel[2];

endmodule

`default_nettype wire

/* rtl/imu_fifo_word_unpacker.sv */
// Channel       Role     Handshake      Payload
// sensor_read   sink     valid/ready    read_ok, byte_zero..byte_six, timestamp_us
// result        source   valid/ready    flags, delta_ns, rate_x..z, accel_x..z
// cfg           write    cfg_we         cfg_index, cfg_data (gyro_gain, accel_gain)
//
// One item is accepted per cycle while the queue is not full, and each item gives one result.
// The front registers decide the mode, count and timing of each item at acceptance.
// A two-entry queue feeds a multiply stage and a sign and output stage.
// Reset clears the mode, count, fault and held accelerometer values at once.
// A stalled result holds the back stages, and input stalls only once the queue fills.
`default_nettype none

module imu_fifo_word_unpacker #(
    parameter int FIFO_LIMIT = imuunp_pkg::FIFO_LIMIT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    imuunp_in_if.sink                               sensor_read,
    imuunp_out_if.source                            result,
    input  wire logic                               cfg_we,
    input  wire logic [imuunp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [imuunp_pkg::GAIN_W-1:0]      cfg_data
);
    import imuunp_pkg::*;

    logic [GAIN_W-1:0] gyro_gain_reg;
    logic [GAIN_W-1:0] accel_gain_reg;

    queue_status_t status;
    cmd_t front_cmd;
    cmd_t head;
    logic queue_full;
    logic queue_not_empty;
    logic pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg <= GYRO_GAIN_RESET;
            accel_gain_reg <= ACCEL_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GYRO_GAIN:  gyro_gain_reg <= cfg_data;
                CFG_ACCEL_GAIN: accel_gain_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    imuunp_front #(
        .FIFO_LIMIT (FIFO_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (sensor_read),
        .queue_full (queue_full),
        .status     (status),
        .cmd        (front_cmd)
    );

    imuunp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    imuunp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .gyro_gain       (gyro_gain_reg),
        .accel_gain      (accel_gain_reg),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .res             (result)
    );

endmodule

`default_nettype wire

/* dv/tb_imu_fifo_word_unpacker.sv */
module tb_imu_fifo_word_unpacker;

    import imuunp_pkg::*;

    localparam int COUNT_LIMIT = FIFO_LIMIT_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SINK_HOLD_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int NUM_PHASES = 6;
    localparam int NUM_DIRECTED = 18;
    localparam int FAULT_ROW = 15;

    typedef struct packed {
        logic ok;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [TIME_W-1:0] ts;
    } sensor_read_t;

    typedef struct packed {
        logic next_is_data;
        logic sample_valid;
        logic accel_fresh;
        logic fault;
        logic [TIME_W-1:0] delta_ns;
        logic [AXIS_W-1:0] rate_x;
        logic [AXIS_W-1:0] rate_y;
        logic [AXIS_W-1:0] rate_z;
        logic [AXIS_W-1:0] accel_x;
        logic [AXIS_W-1:0] accel_y;
        logic [AXIS_W-1:0] accel_z;
    } imu_sample_t;

    typedef struct packed {
        logic ok;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [TIME_W-1:0] ts;
        logic lit;
        logic lit_next;
        logic lit_fault;
    } script_row_t;

    // Rows with lit set carry their expected flags; all other result fields are zero.
    // The last three rows latch the fault, so they are sent only at the very end.
    localparam script_row_t DIRECTED_READS [NUM_DIRECTED] = '{
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'd0, 1'b1, 1'b0, 1'b0},
        '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd5, 1'b1, 1'b0, 1'b0},
        '{1'b1, 8'h03, 8'hFC, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 64'd10, 1'b1, 1'b1, 1'b0},
        '{1'b1, 8'h0F, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 64'd1000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 8'h08, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 64'd1500, 1'b1, 1'b1, 1'b0},
        '{1'b1, 8'h10, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 64'd2000, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'h08, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFE, 8'hFF, 64'd2500, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd3000, 1'b1, 1'b1, 1'b0},
        '{1'b1, 8'h07, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 64'd3100, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'hF8, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 64'd3200, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd3300, 1'b1, 1'b1, 1'b0},
        '{1'b1, 8'h17, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'd3400, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'h09, 8'h34, 8'h12, 8'hCD, 8'hAB, 8'h00, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b0, 1'b0, 1'b0},
        '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd4000, 1'b1, 1'b1, 1'b0},
        '{1'b1, 8'h08, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 64'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd5000, 1'b1, 1'b0, 1'b1},
        '{1'b1, 8'h0F, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h11, 8'h22, 64'd6000, 1'b1, 1'b0, 1'b1},
        '{1'b0, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'd7000, 1'b1, 1'b0, 1'b1}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    imuunp_in_if sensor_read ();
    imuunp_out_if result ();

    imu_fifo_word_unpacker #(
        .FIFO_LIMIT(COUNT_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sensor_read(sensor_read),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [GAIN_W-1:0] gyro_gain_now = GYRO_GAIN_RESET;
    logic [GAIN_W-1:0] accel_gain_now = ACCEL_GAIN_RESET;
    logic in_data_mode = 1'b0;
    logic [COUNT_W-1:0] words_to_go = '0;
    logic [AXIS_W-1:0] accel_hold [NUM_AXES] = '{default: '0};
    logic accel_new = 1'b0;
    logic [TIME_W-1:0] last_gyro_us = '0;
    logic fault_latched = 1'b0;

    imu_sample_t sample_q [$];
    int pending = 0;
    int errors = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit hold_sink = 1'b0;
    logic [TIME_W-1:0] clock_us = '0;

    function automatic logic [AXIS_W-1:0] apply_gain(input logic [7:0] lo, input logic [7:0] hi,
                                                     input logic [GAIN_W-1:0] gain);
        logic [15:0] raw;
        logic [16:0] mag;
        logic [63:0] prod;
        raw = {hi, lo};
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        prod = (64'(mag) * 64'(gain)) >> 24;
        if (raw[15])
        begin
            prod = -prod;
        end
        return prod[AXIS_W-1:0];
    endfunction

    function automatic imu_sample_t decode_read(input sensor_read_t rd);
        imu_sample_t s;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0] tag;
        s = '0;
        if (fault_latched)
        begin
            s.fault = 1'b1;
            return s;
        end
        if (!rd.ok)
        begin
            s.next_is_data = in_data_mode;
            return s;
        end
        if (!in_data_mode)
        begin
            count = {rd.b1[1:0], rd.b0};
            words_to_go = count;
            in_data_mode = (count != 0);
            if (count > COUNT_LIMIT)
            begin
                fault_latched = 1'b1;
                s.fault = 1'b1;
                return s;
            end
        end
        else
        begin
            tag = rd.b0[7:3];
            if (tag == TAG_GYRO)
            begin
                s.sample_valid = 1'b1;
                s.accel_fresh = accel_new;
                s.delta_ns = (rd.ts - last_gyro_us) * 64'd1000;
                s.rate_x = apply_gain(rd.b1, rd.b2, gyro_gain_now);
                s.rate_y = apply_gain(rd.b3, rd.b4, gyro_gain_now);
                s.rate_z = apply_gain(rd.b5, rd.b6, gyro_gain_now);
                s.accel_x = accel_hold[0];
                s.accel_y = accel_hold[1];
                s.accel_z = accel_hold[2];
                accel_new = 1'b0;
                last_gyro_us = rd.ts;
            end
            else if (tag == TAG_ACCEL)
            begin
                accel_hold[0] = apply_gain(rd.b1, rd.b2, accel_gain_now);
                accel_hold[1] = apply_gain(rd.b3, rd.b4, accel_gain_now);
                accel_hold[2] = apply_gain(rd.b5, rd.b6, accel_gain_now);
                accel_new = 1'b1;
            end
            words_to_go = words_to_go - 1'b1;
            if (words_to_go == 0)
            begin
                in_data_mode = 1'b0;
            end
        end
        s.next_is_data = in_data_mode;
        return s;
    endfunction

    // Mostly well-formed traffic: counts the block accepts, then gyro and accel words.
    function automatic sensor_read_t make_read();
        sensor_read_t rd;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0] tag;
        int pick;
        rd.ok = ($urandom_range(99) >= 8);
        rd.b0 = 8'($urandom);
        rd.b1 = 8'($urandom);
        rd.b2 = 8'($urandom);
        rd.b3 = 8'($urandom);
        rd.b4 = 8'($urandom);
        rd.b5 = 8'($urandom);
        rd.b6 = 8'($urandom);
        if ($urandom_range(29) == 0)
        begin
            clock_us = {$urandom, $urandom};
        end
        else
        begin
            clock_us = clock_us + $urandom_range(1, 5000);
        end
        rd.ts = clock_us;
        pick = $urandom_range(99);
        if (!in_data_mode)
        begin
            if (pick < 3)
            begin
                count = '0;
            end
            else if (pick == 3)
            begin
                count = COUNT_W'(COUNT_LIMIT);
            end
            else if (pick == 4)
            begin
                count = COUNT_W'($urandom_range(64, COUNT_LIMIT - 1));
            end
            else
            begin
                count = COUNT_W'($urandom_range(1, 10));
            end
            rd.b0 = count[7:0];
            rd.b1[1:0] = count[9:8];
        end
        else
        begin
            if (pick < 45)
            begin
                tag = TAG_GYRO;
            end
            else if (pick < 85)
            begin
                tag = TAG_ACCEL;
            end
            else
            begin
                tag = TAG_W'($urandom);
            end
            rd.b0[7:3] = tag;
        end
        return rd;
    endfunction

    task automatic send_read(input sensor_read_t rd, input logic lit, input imu_sample_t lit_s);
        imu_sample_t s;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            sensor_read.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sensor_read.valid <= 1'b1;
        sensor_read.read_ok <= rd.ok;
        sensor_read.byte_zero <= rd.b0;
        sensor_read.byte_one <= rd.b1;
        sensor_read.byte_two <= rd.b2;
        sensor_read.byte_three <= rd.b3;
        sensor_read.byte_four <= rd.b4;
        sensor_read.byte_five <= rd.b5;
        sensor_read.byte_six <= rd.b6;
        sensor_read.timestamp_us <= rd.ts;
        @(posedge clk);
        while (!sensor_read.ready)
        begin
            @(posedge clk);
        end
        s = decode_read(rd);
        if (lit)
        begin
            s = lit_s;
        end
        sample_q.push_back(s);
        pending++;
    endtask

    task automatic send_rows(input int first, input int last);
        sensor_read_t rd;
        imu_sample_t lit_s;
        script_row_t row;
        for (int i = first; i < last; i++)
        begin
            row = DIRECTED_READS[i];
            rd = '{row.ok, row.b0, row.b1, row.b2, row.b3, row.b4, row.b5, row.b6, row.ts};
            lit_s = '0;
            lit_s.next_is_data = row.lit_next;
            lit_s.fault = row.lit_fault;
            send_read(rd, row.lit, lit_s);
        end
    endtask

    task automatic drain();
        sensor_read.valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] gyro, input logic [GAIN_W-1:0] accel);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GYRO_GAIN;
        cfg_data <= gyro;
        @(posedge clk);
        cfg_index <= CFG_ACCEL_GAIN;
        cfg_data <= accel;
        @(posedge clk);
        cfg_we <= 1'b0;
        gyro_gain_now = gyro;
        accel_gain_now = accel;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("imu_fifo_word_unpacker test failed");
                $finish;
            end
        end
    end

    // The receiver holds off for a long stretch on request, so that the block backs up.
    initial
    begin
        forever
        begin
            if (hold_sink)
            begin
                result.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        imu_sample_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (sample_q.size() == 0)
            begin
                $error("result item with no item outstanding");
                errors++;
            end
            else
            begin
                want = sample_q.pop_front();
                pending--;
                check_field("next_is_data", 64'(want.next_is_data), 64'(result.next_is_data));
                check_field("sample_valid", 64'(want.sample_valid), 64'(result.sample_valid));
                check_field("accel_fresh", 64'(want.accel_fresh), 64'(result.accel_fresh));
                check_field("fault", 64'(want.fault), 64'(result.fault));
                check_field("delta_ns", want.delta_ns, result.delta_ns);
                check_field("rate_x", 64'(want.rate_x), 64'($unsigned(result.rate_x)));
                check_field("rate_y", 64'(want.rate_y), 64'($unsigned(result.rate_y)));
                check_field("rate_z", 64'(want.rate_z), 64'($unsigned(result.rate_z)));
                check_field("accel_x", 64'(want.accel_x), 64'($unsigned(result.accel_x)));
                check_field("accel_y", 64'(want.accel_y), 64'($unsigned(result.accel_y)));
                check_field("accel_z", 64'(want.accel_z), 64'($unsigned(result.accel_z)));
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_GYRO_GAIN;
        cfg_data <= '0;
        sensor_read.valid <= 1'b0;
        sensor_read.read_ok <= 1'b0;
        sensor_read.byte_zero <= '0;
        sensor_read.byte_one <= '0;
        sensor_read.byte_two <= '0;
        sensor_read.byte_three <= '0;
        sensor_read.byte_four <= '0;
        sensor_read.byte_five <= '0;
        sensor_read.byte_six <= '0;
        sensor_read.timestamp_us <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 32;
        sink_idle_pct = 64;
        send_rows(0, FAULT_ROW);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0: set_gains('1, '0);
                1: set_gains('0, '1);
                2: set_gains($urandom, $urandom);
                3: set_gains(32'd16777216, 32'd16777216);
                4: set_gains($urandom, $urandom);
                default: set_gains(GYRO_GAIN_RESET, ACCEL_GAIN_RESET);
            endcase
            if (p < 2)
            begin
                src_idle_pct = 32;
                sink_idle_pct = 64;
            end
            else if (p < 4)
            begin
                src_idle_pct = 64;
                sink_idle_pct = 32;
            end
            else
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 4 && n == 60)
                begin
                    hold_sink = 1'b1;
                end
                if (p == 4 && n == 150)
                begin
                    drain();
                end
                send_read(make_read(), 1'b0, '0);
            end
        end

        // The fault rows need the block back in status mode.
        while (in_data_mode)
        begin
            send_read(make_read(), 1'b0, '0);
        end
        drain();
        send_rows(FAULT_ROW, NUM_DIRECTED);
        drain();
        repeat (16) @(posedge clk);

        if (errors == 0)
        begin
            $display("imu_fifo_word_unpacker test passed");
        end
        else
        begin
            $display("imu_fifo_word_unpacker test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/imuunp_pkg.sv
rtl/imuunp_if.sv
rtl/imuunp_front.sv
rtl/imuunp_queue.sv
rtl/imuunp_back.sv
rtl/imu_fifo_word_unpacker.sv
dv/tb_imu_fifo_word_unpacker.sv
